// File: rtl/core/mpe_pkg.sv
// shared constants and types for the mandelbrot escape-time pixel core
// no dependencies
`timescale 1ns / 1ps

package mpe_pkg;

	localparam int FRAC_BITS_DEF   = 28;
	localparam int COUNT_WIDTH_DEF = 12;

	// multiplier digit handled by one cell of the chain
	localparam int DIGIT_W = 8;

	// width that holds c exactly for any register contents
	localparam int C_WIDTH = 47;

	localparam logic [2:0] CFG_LEFT_RE       = 3'd0;
	localparam logic [2:0] CFG_BOTTOM_IM     = 3'd1;
	localparam logic [2:0] CFG_STEP_RE       = 3'd2;
	localparam logic [2:0] CFG_STEP_IM       = 3'd3;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd4;
	localparam logic [2:0] CFG_MAX_ITER      = 3'd5;

	localparam int DIM_COUNT = 5;

	localparam logic [7:0] DIM_RED   = 8'd11;
	localparam logic [7:0] DIM_GREEN = 8'd14;
	localparam logic [7:0] DIM_BLUE  = 8'd20;

	localparam logic [7:0] SCALE_RED   = 8'd150;
	localparam logic [7:0] SCALE_GREEN = 8'd40;
	localparam logic [7:0] SCALE_BLUE  = 8'd60;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

endpackage

// File: rtl/core/mpe_mul_cell.sv
// one cell of the multiplier chain: adds operand times one digit to three running sums
// depends on mpe_pkg
`timescale 1ns / 1ps

module mpe_mul_cell import mpe_pkg::*; #(
	parameter int MW  = 31,
	parameter int BW  = 32,
	parameter int PW  = 63,
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vld_in,
	input  logic [2:0][MW-1:0]     a_in,
	input  logic [2:0][BW-1:0]     b_in,
	input  logic [2:0][PW-1:0]     acc_in,
	output logic                   vld_out,
	output logic [2:0][MW-1:0]     a_out,
	output logic [2:0][BW-1:0]     b_out,
	output logic [2:0][PW-1:0]     acc_out
);

	localparam int SHIFT = DIGIT_W * IDX;

	logic [2:0][MW+DIGIT_W-1:0] part;
	logic [2:0][PW-1:0]         acc_nxt;
	logic                       vld_q;
	logic [2:0][MW-1:0]         a_q;
	logic [2:0][BW-1:0]         b_q;
	logic [2:0][PW-1:0]         acc_q;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			part[j]    = (MW+DIGIT_W)'(a_in[j]) * (MW+DIGIT_W)'(b_in[j][SHIFT +: DIGIT_W]);
			acc_nxt[j] = acc_in[j] + (PW'(part[j]) << SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			a_q   <= '0;
			b_q   <= '0;
			acc_q <= '0;
		end else begin
			vld_q <= vld_in;
			a_q   <= a_in;
			b_q   <= b_in;
			acc_q <= acc_nxt;
		end
	end

	assign vld_out = vld_q;
	assign a_out   = a_q;
	assign b_out   = b_q;
	assign acc_out = acc_q;

endmodule

// File: rtl/core/mpe_mul_chain.sv
// row of multiplier cells forming three unsigned products, one digit per cell
// depends on mpe_pkg and mpe_mul_cell
`timescale 1ns / 1ps

module mpe_mul_chain import mpe_pkg::*; #(
	parameter int MW = 31,
	parameter int ND = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [2:0][MW-1:0]                a_in,
	input  logic [2:0][ND*DIGIT_W-1:0]        b_in,
	output logic                              vld_out,
	output logic [2:0][MW+ND*DIGIT_W-1:0]     prod
);

	localparam int BW = ND * DIGIT_W;
	localparam int PW = MW + BW;

	logic [ND:0]               vld_w;
	logic [ND:0][2:0][MW-1:0]  a_w;
	logic [ND:0][2:0][BW-1:0]  b_w;
	logic [ND:0][2:0][PW-1:0]  acc_w;

	assign vld_w[0] = start;
	assign a_w[0]   = a_in;
	assign b_w[0]   = b_in;
	assign acc_w[0] = '0;

	for (genvar k = 0; k < ND; k++) begin : g_cell
		mpe_mul_cell #(
			.MW  (MW),
			.BW  (BW),
			.PW  (PW),
			.IDX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_w[k]),
			.a_in    (a_w[k]),
			.b_in    (b_w[k]),
			.acc_in  (acc_w[k]),
			.vld_out (vld_w[k+1]),
			.a_out   (a_w[k+1]),
			.b_out   (b_w[k+1]),
			.acc_out (acc_w[k+1])
		);
	end

	assign vld_out = vld_w[ND];
	assign prod    = acc_w[ND];

endmodule

// File: rtl/core/mpe_color_div.sv
// restoring divider giving the three scaled color channels, one quotient bit a cycle
// depends on mpe_pkg
`timescale 1ns / 1ps

module mpe_color_div import mpe_pkg::*; #(
	parameter int CW = COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] n,
	input  logic [CW-1:0] limit,
	output logic          done,
	output color_t        color
);

	localparam int DW = CW + 8;
	localparam logic [2:0][7:0] SCALES = {SCALE_BLUE, SCALE_GREEN, SCALE_RED};

	logic [2:0][DW-1:0] rem_q;
	logic [2:0][7:0]    quo_q;
	logic [2:0]         bit_q;
	logic               busy_q;
	logic               done_q;
	logic [DW-1:0]      dsr;

	assign dsr = DW'(limit) << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				for (int j = 0; j < 3; j++) begin
					rem_q[j] <= DW'(n) * DW'(SCALES[j]);
				end
				bit_q  <= 3'd7;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				for (int j = 0; j < 3; j++) begin
					if (rem_q[j] >= dsr) begin
						rem_q[j]        <= rem_q[j] - dsr;
						quo_q[j][bit_q] <= 1'b1;
					end else begin
						quo_q[j][bit_q] <= 1'b0;
					end
				end
				if (bit_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 3'd1;
				end
			end
		end
	end

	assign done        = done_q;
	assign color.red   = quo_q[0];
	assign color.green = quo_q[1];
	assign color.blue  = quo_q[2];

endmodule

// File: rtl/core/mandelbrot_pixel_escape_color_core.sv
// mandelbrot escape-time pixel core: maps a pixel to c, iterates z = z*z + c, colors the count
// depends on mpe_pkg, mpe_mul_chain, mpe_color_div
// sequence: a setup step, then per iteration the multiplier chain and the escape test, then a color
// step, the divider for a scaled color, and the hand-over to the output register
// one pixel at a time: in_stall stays high until the result is handed over; out_stall can hold it
// reset: arst_n clears the registers to their power-on values and leaves the core idle
`timescale 1ns / 1ps

module mandelbrot_pixel_escape_color_core import mpe_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] iter_count,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int MW = FRAC_BITS + 3;
	localparam int ND = (MW + DIGIT_W - 1) / DIGIT_W;
	localparam int BW = ND * DIGIT_W;
	localparam int PW = MW + BW;
	localparam int SW = PW + 1;
	localparam int ZW = ((C_WIDTH > FRAC_BITS + 5) ? C_WIDTH : FRAC_BITS + 5) + 2;

	localparam logic signed [ZW-1:0] TWO     = ZW'(2) << FRAC_BITS;
	localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
	localparam logic signed [ZW:0]   FOUR    = (ZW+1)'(4) << FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_ISSUE,
		S_WAIT,
		S_COLOR,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	logic signed [31:0] left_re_q;
	logic signed [31:0] bottom_im_q;
	logic [30:0]        step_re_q;
	logic [30:0]        step_im_q;
	logic [12:0]        height_q;
	logic [11:0]        iter_limit_q;

	logic [11:0]             px_q;
	logic [11:0]             py_q;
	logic signed [ZW-1:0]    cr_q;
	logic signed [ZW-1:0]    ci_q;
	logic signed [ZW-1:0]    zr_q;
	logic signed [ZW-1:0]    zi_q;
	logic [COUNT_WIDTH-1:0]  n_q;
	logic [2:0]              neg_q;
	color_t                  color_q;

	logic        out_valid_q;
	logic [11:0] iter_count_q;
	color_t      out_color_q;

	logic [COUNT_WIDTH-1:0]  limit;
	logic signed [44:0]      xprod;
	logic signed [13:0]      rows;
	logic signed [45:0]      yprod;
	logic signed [ZW-1:0]    abs_zr;
	logic signed [ZW-1:0]    abs_zi;
	logic                    escaped;
	logic                    mul_start;
	logic [2:0][MW-1:0]      mul_a;
	logic [2:0][BW-1:0]      mul_b;
	logic                    mul_vld;
	logic [2:0][PW-1:0]      mul_prod;
	logic signed [SW-1:0]    sgn [3];
	logic signed [SW-1:0]    shv [3];
	logic signed [ZW-1:0]    prod_z [3];
	logic signed [ZW:0]      sq_sum;
	logic                    div_start;
	logic                    div_done;
	color_t                  div_color;

	assign limit = COUNT_WIDTH'(iter_limit_q);

	// c, formed exactly
	assign xprod = $signed({1'b0, px_q}) * $signed({1'b0, step_re_q});
	assign rows  = $signed({1'b0, height_q}) - $signed({2'b00, py_q});
	assign yprod = rows * $signed({1'b0, step_im_q});

	assign abs_zr  = (zr_q < 0) ? -zr_q : zr_q;
	assign abs_zi  = (zi_q < 0) ? -zi_q : zi_q;
	assign escaped = (zr_q > TWO) || (zr_q < NEG_TWO) || (zi_q > TWO) || (zi_q < NEG_TWO);

	assign mul_start = (state_q == S_ISSUE) && (n_q != limit) && !escaped;

	// operands: zr*zr, zi*zi, 2zr*zi
	always_comb begin
		mul_a[0] = abs_zr[MW-1:0];
		mul_a[1] = abs_zi[MW-1:0];
		mul_a[2] = MW'(abs_zr[MW-1:0] << 1);
		mul_b[0] = BW'(abs_zr[MW-1:0]);
		mul_b[1] = BW'(abs_zi[MW-1:0]);
		mul_b[2] = BW'(abs_zi[MW-1:0]);
	end

	mpe_mul_chain #(
		.MW (MW),
		.ND (ND)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a_in    (mul_a),
		.b_in    (mul_b),
		.vld_out (mul_vld),
		.prod    (mul_prod)
	);

	// sign back on, then floor shift
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sgn[j]    = neg_q[j] ? -$signed({1'b0, mul_prod[j]}) : $signed({1'b0, mul_prod[j]});
			shv[j]    = sgn[j] >>> FRAC_BITS;
			prod_z[j] = ZW'(shv[j]);
		end
	end

	assign sq_sum = (ZW+1)'(prod_z[0]) + (ZW+1)'(prod_z[1]);

	assign div_start = (state_q == S_COLOR) && (n_q != limit)
		&& (n_q >= COUNT_WIDTH'(DIM_COUNT));

	mpe_color_div #(
		.CW (COUNT_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (n_q),
		.limit  (limit),
		.done   (div_done),
		.color  (div_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_re_q    <= -32'sd536870912;
			bottom_im_q  <= -32'sd402653184;
			step_re_q    <= 31'd1048576;
			step_im_q    <= 31'd1048576;
			height_q     <= 13'd768;
			iter_limit_q <= 12'd64;
			state_q      <= S_IDLE;
			px_q         <= '0;
			py_q         <= '0;
			cr_q         <= '0;
			ci_q         <= '0;
			zr_q         <= '0;
			zi_q         <= '0;
			n_q          <= '0;
			neg_q        <= '0;
			color_q      <= '0;
			out_valid_q  <= 1'b0;
			iter_count_q <= '0;
			out_color_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LEFT_RE:       left_re_q    <= $signed(cfg_data);
					CFG_BOTTOM_IM:     bottom_im_q  <= $signed(cfg_data);
					CFG_STEP_RE:       step_re_q    <= cfg_data[30:0];
					CFG_STEP_IM:       step_im_q    <= cfg_data[30:0];
					CFG_SCREEN_HEIGHT: height_q     <= cfg_data[12:0];
					CFG_MAX_ITER:      iter_limit_q <= cfg_data[11:0];
					default: ;
				endcase
			end

			// in the done state the hand-over below decides the output valid
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q    <= pixel_x;
						py_q    <= pixel_y;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					cr_q    <= ZW'(left_re_q) + ZW'(xprod);
					ci_q    <= ZW'(bottom_im_q) + ZW'(yprod);
					zr_q    <= '0;
					zi_q    <= '0;
					n_q     <= '0;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					if (mul_start) begin
						neg_q   <= {(zr_q < 0) != (zi_q < 0), 2'b00};
						state_q <= S_WAIT;
					end else begin
						state_q <= S_COLOR;
					end
				end
				S_WAIT: begin
					if (mul_vld) begin
						if (sq_sum > FOUR) begin
							state_q <= S_COLOR;
						end else begin
							zr_q    <= prod_z[0] - prod_z[1] + cr_q;
							zi_q    <= prod_z[2] + ci_q;
							n_q     <= n_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_COLOR: begin
					if (n_q == limit) begin
						color_q <= '0;
						state_q <= S_DONE;
					end else if (n_q < COUNT_WIDTH'(DIM_COUNT)) begin
						color_q <= '{red: DIM_RED, green: DIM_GREEN, blue: DIM_BLUE};
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						color_q <= div_color;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hand over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						iter_count_q <= 12'(n_q);
						out_color_q  <= color_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign iter_count = iter_count_q;
	assign red        = out_color_q.red;
	assign green      = out_color_q.green;
	assign blue       = out_color_q.blue;

`ifndef NO_ASSERTIONS
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_SETUP)
		else $error("accepted word did not start setup");
	a_chain_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_vld |-> state_q == S_WAIT)
		else $error("product arrived outside wait");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ISSUE |-> n_q <= limit)
		else $error("iteration count passed the limit");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");
`endif

endmodule
